[sv/mch_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mch_pkg
// Shared widths, codes, command and status types, and the constant tables
// for the magnetometer calibration and heading unit.
// ----------------------------------------------------------------------------
package mch_pkg;

    localparam int RAW_W   = 16;
    localparam int MG_W    = 17;
    localparam int HEAD_W  = 16;
    localparam int CNT_W   = 16;
    localparam int RANGE_W = 2;
    localparam int CFG_W   = 16;
    localparam int AXES    = 3;
    localparam int AXIS_W  = 2;
    localparam int STEP_W  = 5;
    localparam int MAX_STEPS = 24;

    localparam int DIFF_W  = 18;
    localparam int SUM_W   = 19;
    localparam int PROD_W  = 38;
    localparam int N_W     = 48;
    localparam int REM_W   = 47;
    localparam int D_W     = 34;
    localparam int Q_W     = 18;
    localparam int DSH_W   = D_W + Q_W - 1;
    localparam int CORD_W  = 32;
    localparam int ANG_W   = 32;

    localparam logic [0:0] CFG_RANGE = 1'b0;
    localparam logic [0:0] CFG_COUNT = 1'b1;
    localparam logic       FUNC_CAL  = 1'b1;

    localparam logic [RANGE_W-1:0] RANGE_2G  = 2'd0;
    localparam logic [RANGE_W-1:0] RANGE_8G  = 2'd1;
    localparam logic [RANGE_W-1:0] RANGE_12G = 2'd2;
    localparam logic [RANGE_W-1:0] RANGE_30G = 2'd3;

    typedef struct packed {
        logic              load;
        logic              mul;
        logic              scale;
        logic              absn;
        logic              div_step;
        logic              div_last;
        logic              cordic_init;
        logic              cordic_step;
        logic              angle;
        logic              finish;
        logic [AXIS_W-1:0] axis;
        logic [STEP_W-1:0] step_idx;
    } mch_cmd_t;

    typedef struct packed {
        logic out_busy;
    } mch_status_t;

    // Counts per gauss for the selected range.
    function automatic logic [D_W-1:0] cpg_of(input logic [RANGE_W-1:0] r);
        logic [D_W-1:0] v;
        case (r)
            RANGE_2G:  v = D_W'(15000);
            RANGE_8G:  v = D_W'(3750);
            RANGE_12G: v = D_W'(2500);
            RANGE_30G: v = D_W'(1000);
            default:   v = D_W'(15000);
        endcase
        return v;
    endfunction

    // Six times the counts per gauss, used with the full span.
    function automatic logic [16:0] six_cpg_of(input logic [RANGE_W-1:0] r);
        logic [16:0] v;
        case (r)
            RANGE_2G:  v = 17'd90000;
            RANGE_8G:  v = 17'd22500;
            RANGE_12G: v = 17'd15000;
            RANGE_30G: v = 17'd6000;
            default:   v = 17'd90000;
        endcase
        return v;
    endfunction

    // Arctangent of 2^-i as a binary angle, 2^32 being a full turn.
    function automatic logic [ANG_W-1:0] atan_of(input logic [STEP_W-1:0] i);
        logic [ANG_W-1:0] v;
        case (i)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2F9;
            5'd15:   v = 32'h0000517C;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A2F;
            5'd19:   v = 32'h00000517;
            5'd20:   v = 32'h0000028B;
            5'd21:   v = 32'h00000145;
            5'd22:   v = 32'h000000A2;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[sv/mch_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mch_ctrl
// Sequencer: walks one word through multiply, divide, CORDIC and finish.
// ----------------------------------------------------------------------------
module mch_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  mch_pkg::mch_status_t     status,
    output mch_pkg::mch_cmd_t        cmd
);

    localparam int EFF_STEPS = (CORDIC_STEPS > mch_pkg::MAX_STEPS) ?
                               mch_pkg::MAX_STEPS : CORDIC_STEPS;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_SCALE = 4'd2;
    localparam logic [3:0] S_ABS   = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_CINIT = 4'd5;
    localparam logic [3:0] S_CORD  = 4'd6;
    localparam logic [3:0] S_ANGLE = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    localparam logic [mch_pkg::STEP_W-1:0] DIV_LAST  = mch_pkg::STEP_W'(mch_pkg::Q_W - 1);
    localparam logic [mch_pkg::STEP_W-1:0] CORD_LAST = mch_pkg::STEP_W'(EFF_STEPS - 1);
    localparam logic [mch_pkg::AXIS_W-1:0] AXIS_LAST = mch_pkg::AXIS_W'(mch_pkg::AXES - 1);

    logic [3:0]                  state_reg, state_next;
    logic [mch_pkg::STEP_W-1:0]  cnt_reg, cnt_next;
    logic [mch_pkg::AXIS_W-1:0]  axis_reg, axis_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        axis_next  = axis_reg;
        cmd        = '0;
        cmd.axis     = axis_reg;
        cmd.step_idx = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    axis_next  = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_ABS;
            end
            S_ABS:
            begin
                cmd.absn   = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    cmd.div_last = 1'b1;
                    if (axis_reg == AXIS_LAST)
                    begin
                        state_next = S_CINIT;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = S_MUL;
                    end
                end
            end
            S_CINIT:
            begin
                cmd.cordic_init = 1'b1;
                cnt_next        = '0;
                state_next      = S_CORD;
            end
            S_CORD:
            begin
                cmd.cordic_step = 1'b1;
                cnt_next        = cnt_reg + 1'b1;
                if (cnt_reg == CORD_LAST)
                begin
                    state_next = S_ANGLE;
                end
            end
            S_ANGLE:
            begin
                cmd.angle  = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            axis_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            axis_reg  <= axis_next;
        end
    end

endmodule
`default_nettype wire

[sv/mch_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mch_datapath
// Calibration state, scaling multipliers, restoring divider, CORDIC and the
// output register.
// ----------------------------------------------------------------------------
module mch_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  mch_pkg::mch_cmd_t                      cmd,
    output mch_pkg::mch_status_t                   status,
    input  wire logic                              cfg_we,
    input  wire logic [0:0]                        cfg_index,
    input  wire logic [mch_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic                              func,
    input  wire logic signed [mch_pkg::RAW_W-1:0]  raw_x,
    input  wire logic signed [mch_pkg::RAW_W-1:0]  raw_y,
    input  wire logic signed [mch_pkg::RAW_W-1:0]  raw_z,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [mch_pkg::MG_W-1:0]        mag_x_mgauss,
    output logic signed [mch_pkg::MG_W-1:0]        mag_y_mgauss,
    output logic signed [mch_pkg::MG_W-1:0]        mag_z_mgauss,
    output logic [mch_pkg::HEAD_W-1:0]             heading_centideg,
    output logic                                   cal_valid,
    output logic                                   cal_done
);

    localparam int RAW_W = mch_pkg::RAW_W;
    localparam int MG_W  = mch_pkg::MG_W;
    localparam int AXES  = mch_pkg::AXES;

    // Configuration.
    logic [mch_pkg::RANGE_W-1:0] range_reg;
    logic [mch_pkg::CNT_W-1:0]   count_reg;

    // Calibration state.
    logic signed [RAW_W-1:0]     min_reg [AXES];
    logic signed [RAW_W-1:0]     max_reg [AXES];
    logic signed [MG_W-1:0]      ct_reg  [AXES];
    logic [MG_W-1:0]             sf_reg  [AXES];
    logic [mch_pkg::SUM_W-1:0]   ss_reg;
    logic [mch_pkg::CNT_W-1:0]   idx_reg;

    // Work registers.
    logic                        func_reg;
    logic                        valid_reg;
    logic signed [RAW_W-1:0]     raw_reg [AXES];
    logic signed [mch_pkg::PROD_W-1:0] prod_reg;
    logic [mch_pkg::D_W-1:0]     d_reg;
    logic signed [mch_pkg::N_W-1:0] n_reg;
    logic                        neg_reg;
    logic [mch_pkg::REM_W-1:0]   rem_reg;
    logic [mch_pkg::DSH_W-1:0]   dsh_reg;
    logic [mch_pkg::Q_W-1:0]     q_reg;
    logic signed [MG_W-1:0]      mg_reg [AXES];
    logic signed [mch_pkg::CORD_W-1:0] x_reg, y_reg;
    logic [mch_pkg::ANG_W-1:0]   ang_reg;
    logic                        zero_reg;
    logic [mch_pkg::HEAD_W-1:0]  head_reg;
    logic                        out_valid_reg;

    // Scaling.
    logic signed [RAW_W-1:0]          raw_sel;
    logic signed [mch_pkg::DIFF_W-1:0] diff;
    logic signed [mch_pkg::PROD_W-1:0] prod_next;
    logic [mch_pkg::D_W-1:0]          d_next;
    logic signed [mch_pkg::N_W-1:0]   n_next;
    logic [mch_pkg::N_W-1:0]          n_mag;
    logic                             cal_ok;

    assign cal_ok  = (sf_reg[0] != '0) && (sf_reg[1] != '0) && (sf_reg[2] != '0);
    assign raw_sel = raw_reg[cmd.axis];
    assign diff    = (mch_pkg::DIFF_W'(raw_sel) <<< 1) - mch_pkg::DIFF_W'(ct_reg[cmd.axis]);

    always_comb
    begin
        if (valid_reg)
        begin
            prod_next = mch_pkg::PROD_W'(diff) *
                        mch_pkg::PROD_W'($signed({1'b0, ss_reg}));
            d_next    = mch_pkg::D_W'(sf_reg[cmd.axis]) *
                        mch_pkg::D_W'(mch_pkg::six_cpg_of(range_reg));
        end
        else
        begin
            prod_next = mch_pkg::PROD_W'(raw_sel);
            d_next    = mch_pkg::cpg_of(range_reg);
        end
    end

    assign n_next = mch_pkg::N_W'(prod_reg) * mch_pkg::N_W'(1000);
    assign n_mag  = n_reg[mch_pkg::N_W-1] ? mch_pkg::N_W'(-n_reg) : mch_pkg::N_W'(n_reg);

    // Restoring divider, one quotient bit a cycle.
    logic                         div_ge;
    logic [mch_pkg::Q_W-1:0]      q_next;
    logic signed [MG_W-1:0]       mg_sat;

    assign div_ge = {{(mch_pkg::DSH_W - mch_pkg::REM_W){1'b0}}, rem_reg} >= dsh_reg;
    assign q_next = {q_reg[mch_pkg::Q_W-2:0], div_ge};

    always_comb
    begin
        if (neg_reg)
        begin
            if (q_next > mch_pkg::Q_W'(65536))
                mg_sat = -MG_W'(65536);
            else
                mg_sat = MG_W'(-$signed({1'b0, q_next}));
        end
        else
        begin
            if (q_next > mch_pkg::Q_W'(65535))
                mg_sat = MG_W'(65535);
            else
                mg_sat = MG_W'(q_next);
        end
    end

    // CORDIC.
    logic signed [mch_pkg::CORD_W-1:0] x0, y0, dx, dy;
    logic [47:0]                       deg_prod;
    logic [mch_pkg::HEAD_W-1:0]        deg_cd;

    assign x0 = mch_pkg::CORD_W'(mg_reg[0]) <<< 12;
    assign y0 = mch_pkg::CORD_W'(mg_reg[1]) <<< 12;
    assign dx = y_reg >>> cmd.step_idx;
    assign dy = x_reg >>> cmd.step_idx;
    assign deg_prod = 48'(ang_reg) * 48'd36000 + 48'h0000_8000_0000;
    assign deg_cd   = deg_prod[47:32];

    // Calibration update for a calibration word.
    logic signed [RAW_W-1:0]   nmin [AXES];
    logic signed [RAW_W-1:0]   nmax [AXES];
    logic [mch_pkg::CNT_W-1:0] count_eff;
    logic                      run_end;

    always_comb
    begin
        for (int k = 0; k < AXES; k++)
        begin
            nmin[k] = (idx_reg == '0 || raw_reg[k] < min_reg[k]) ? raw_reg[k] : min_reg[k];
            nmax[k] = (idx_reg == '0 || raw_reg[k] > max_reg[k]) ? raw_reg[k] : max_reg[k];
        end
    end

    assign count_eff = (count_reg == '0) ? mch_pkg::CNT_W'(1) : count_reg;
    assign run_end   = ({1'b0, idx_reg} + 17'd1) >= {1'b0, count_eff};

    // Work registers, no reset needed.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg   <= func;
            valid_reg  <= cal_ok;
            raw_reg[0] <= raw_x;
            raw_reg[1] <= raw_y;
            raw_reg[2] <= raw_z;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
            d_reg    <= d_next;
        end
        if (cmd.scale)
        begin
            n_reg <= n_next;
        end
        if (cmd.absn)
        begin
            neg_reg <= n_reg[mch_pkg::N_W-1];
            rem_reg <= mch_pkg::REM_W'(n_mag) + mch_pkg::REM_W'(d_reg >> 1);
            dsh_reg <= {d_reg, {(mch_pkg::Q_W-1){1'b0}}};
            q_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            if (div_ge)
                rem_reg <= rem_reg - dsh_reg[mch_pkg::REM_W-1:0];
            dsh_reg <= dsh_reg >> 1;
            q_reg   <= q_next;
        end
        if (cmd.div_last)
        begin
            mg_reg[cmd.axis] <= mg_sat;
        end
        if (cmd.cordic_init)
        begin
            zero_reg <= (mg_reg[0] == '0) && (mg_reg[1] == '0);
            if (x0 < 0)
            begin
                x_reg   <= -x0;
                y_reg   <= -y0;
                ang_reg <= 32'h8000_0000;
            end
            else
            begin
                x_reg   <= x0;
                y_reg   <= y0;
                ang_reg <= '0;
            end
        end
        if (cmd.cordic_step)
        begin
            if (y_reg >= 0)
            begin
                x_reg   <= x_reg + dx;
                y_reg   <= y_reg - dy;
                ang_reg <= ang_reg + mch_pkg::atan_of(cmd.step_idx);
            end
            else
            begin
                x_reg   <= x_reg - dx;
                y_reg   <= y_reg + dy;
                ang_reg <= ang_reg - mch_pkg::atan_of(cmd.step_idx);
            end
        end
        if (cmd.angle)
        begin
            if (zero_reg || deg_cd >= mch_pkg::HEAD_W'(36000))
                head_reg <= '0;
            else
                head_reg <= deg_cd;
        end
        if (cmd.finish)
        begin
            mag_x_mgauss     <= mg_reg[0];
            mag_y_mgauss     <= mg_reg[1];
            mag_z_mgauss     <= mg_reg[2];
            heading_centideg <= head_reg;
            cal_valid        <= valid_reg;
            cal_done         <= (func_reg == mch_pkg::FUNC_CAL) && run_end;
        end
    end

    // Configuration, calibration state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg     <= '0;
            count_reg     <= mch_pkg::CNT_W'(256);
            ss_reg        <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < AXES; k++)
            begin
                min_reg[k] <= '0;
                max_reg[k] <= '0;
                ct_reg[k]  <= '0;
                sf_reg[k]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    mch_pkg::CFG_RANGE: range_reg <= cfg_data[mch_pkg::RANGE_W-1:0];
                    mch_pkg::CFG_COUNT: count_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.finish && func_reg == mch_pkg::FUNC_CAL)
            begin
                for (int k = 0; k < AXES; k++)
                begin
                    min_reg[k] <= nmin[k];
                    max_reg[k] <= nmax[k];
                end
                if (run_end)
                begin
                    for (int k = 0; k < AXES; k++)
                    begin
                        ct_reg[k] <= MG_W'(nmax[k]) + MG_W'(nmin[k]);
                        sf_reg[k] <= MG_W'(MG_W'(nmax[k]) - MG_W'(nmin[k]));
                    end
                    ss_reg  <= mch_pkg::SUM_W'(MG_W'(nmax[0]) - MG_W'(nmin[0]))
                             + mch_pkg::SUM_W'(MG_W'(nmax[1]) - MG_W'(nmin[1]))
                             + mch_pkg::SUM_W'(MG_W'(nmax[2]) - MG_W'(nmin[2]));
                    idx_reg <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign status.out_busy = out_valid_reg && !out_ready;

endmodule
`default_nettype wire

[sv/magnetometer_calibrate_heading_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// magnetometer_calibrate_heading_unit
// Hard/soft iron correction, milligauss scaling and CORDIC heading.
// ----------------------------------------------------------------------------
// Usage. Each input word carries func and three signed raw axis counts on a
// valid/ready channel. Every accepted word yields exactly one result word on
// the output valid/ready channel: the three corrected fields in milligauss,
// the heading in hundredths of a degree, and the cal_valid and cal_done flags.
// A calibration word (func = 1) also updates the per-axis min/max tracking;
// its own result still uses the calibration in force before it.
//
// Processing. One word is processed at a time. The word is taken, then each
// axis passes through the multiply, scale and absolute-value steps and the
// restoring divider. A CORDIC setup step follows, then min(CORDIC_STEPS, 24)
// iterations, one per cycle, then the angle scaling and a finish step. The
// divider takes most of the time per word.
//
// Reset clears the calibration (correction off), loads range 0 and a run
// length of 256. The output is registered: a new word is accepted while a
// result waits, but the finish step holds until the receiver takes the
// waiting word. Configuration writes are taken at once on cfg_we.
// ----------------------------------------------------------------------------
module magnetometer_calibrate_heading_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [0:0]                        cfg_index,
    input  wire logic [mch_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              func,
    input  wire logic signed [mch_pkg::RAW_W-1:0]  raw_x,
    input  wire logic signed [mch_pkg::RAW_W-1:0]  raw_y,
    input  wire logic signed [mch_pkg::RAW_W-1:0]  raw_z,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [mch_pkg::MG_W-1:0]        mag_x_mgauss,
    output logic signed [mch_pkg::MG_W-1:0]        mag_y_mgauss,
    output logic signed [mch_pkg::MG_W-1:0]        mag_z_mgauss,
    output logic [mch_pkg::HEAD_W-1:0]             heading_centideg,
    output logic                                   cal_valid,
    output logic                                   cal_done
);

    mch_pkg::mch_cmd_t    cmd;
    mch_pkg::mch_status_t status;

    // The sequencer issues one command set per cycle.
    mch_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds all arithmetic, calibration state and outputs.
    mch_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .func             (func),
        .raw_x            (raw_x),
        .raw_y            (raw_y),
        .raw_z            (raw_z),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .mag_x_mgauss     (mag_x_mgauss),
        .mag_y_mgauss     (mag_y_mgauss),
        .mag_z_mgauss     (mag_z_mgauss),
        .heading_centideg (heading_centideg),
        .cal_valid        (cal_valid),
        .cal_done         (cal_done)
    );

    // A heading never reaches a full turn.
    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (heading_centideg < 16'd36000))
        else $error("heading out of range");

    // Once a word is taken the block stays busy for the following cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("accepted a word while busy");

    // A new result appears only as the sequencer returns to idle.
    a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result raised outside idle");

endmodule
`default_nettype wire
